// ===== design/mfbb_pkg.sv =====
`default_nettype none

package mfbb_pkg;

   // operation codes
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SET   = 2'd2,
      OP_CLEAR = 2'd3
   } mfbb_op_type;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PREP,
      ST_ACCESS,
      ST_CLEAR,
      ST_FINISH
   } mfbb_state_type;

   localparam int unsigned MaxBits = 32;
   localparam logic [12:0] ResetBufferBytes = 13'd4096;

   // request word
   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  bit_count;
      logic [31:0] write_value;
      logic [15:0] new_position;
   } mfbb_req_type;

   // response word
   typedef struct packed {
      logic [31:0] read_value;
      logic [5:0]  read_count;
      logic [15:0] cursor_now;
   } mfbb_rsp_type;

   // low n bits set, n up to 32
   function automatic logic [31:0] low_mask(input logic [5:0] n);
      logic [32:0] full;
      full = (33'd1 << n) - 33'd1;
      return full[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/mfbb_ram.sv =====
`default_nettype none

module mfbb_ram #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/msb_first_bit_buffer.sv =====
`default_nettype none

// msb-first bit buffer: a byte store with a bit cursor
// request channel: a word is taken at a clock edge with start high and busy low.
// opcodes read up to 32 bits at the cursor, or OR up to 32 bits into the store,
// set the cursor (clamped to the end of the bytes in use), or clear the bytes in use.
// response channel: rsp_valid is high for exactly one cycle with one word per
// request; the receiver cannot stall, so the word must be taken in that cycle.
// csr channel: csr_data sets the number of bytes in use; csr_ready is always high.
// write it only while busy is low and no response is outstanding.
// access: read and write touch k bytes (0 to 5) of a one-read one-write byte
// memory with a registered read port, one byte a cycle; with k zero (nothing in
// reach) no byte is touched. busy stays high until the response is registered,
// so no new word is taken while a request is in progress. clear sweeps the bytes
// in use, one a cycle.
// reset: synchronous; the cursor returns to zero, the buffer size to 4096 and
// the whole store is swept to zero while busy is high.

module msb_first_bit_buffer
   import mfbb_pkg::*;
#(
   parameter int unsigned STORE_BYTES = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire mfbb_req_type req_data,
   output logic              rsp_valid,
   output mfbb_rsp_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [12:0]  csr_data
);

   localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam logic [AW-1:0] LastAddr = AW'(STORE_BYTES - 1);
   localparam logic [16:0] StoreBytes17 = 17'(STORE_BYTES);

   mfbb_state_type state_ff, state_in;
   mfbb_req_type   req_ff, req_in;
   logic [15:0]    cur_ff, cur_in;
   logic [12:0]    buf_ff;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [AW-1:0]  sweep_last_ff, sweep_last_in;
   logic [15:0]    end_ff, end_in;
   logic [5:0]     n_ff, n_in;
   logic [2:0]     off_ff, off_in;
   logic [2:0]     k_ff, k_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [39:0]    wide_ff, wide_in;
   logic [39:0]    acc_ff, acc_in;
   logic [2:0]     iss_ff, iss_in;
   logic [2:0]     ret_ff, ret_in;
   logic           pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   mfbb_rsp_type   rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   // setup values derived from the latched request
   logic [12:0] prep_size;
   logic [15:0] prep_end;
   logic [15:0] prep_room;
   logic [5:0]  prep_n;
   logic [5:0]  prep_span;
   logic [2:0]  prep_k;
   logic [5:0]  prep_lsh;
   logic [39:0] prep_wide;

   // response shaping
   logic [5:0]  fin_sh;
   logic [39:0] fin_acc;
   logic [15:0] fin_set;

   mfbb_ram #(
      .DEPTH(STORE_BYTES),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // access geometry: bits that fit before the end and bytes spanned
   always_comb begin
      prep_size = ({4'b0, buf_ff} > StoreBytes17) ? StoreBytes17[12:0] : buf_ff;
      prep_end  = {prep_size, 3'b000};
      prep_room = prep_end - cur_ff;
      if (cur_ff >= prep_end) begin
         prep_n = 6'd0;
      end else if (prep_room < {10'd0, req_ff.bit_count}) begin
         prep_n = prep_room[5:0];
      end else begin
         prep_n = req_ff.bit_count;
      end
      prep_span = {3'b000, cur_ff[2:0]} + prep_n + 6'd7;
      prep_k    = (prep_n == 6'd0) ? 3'd0 : prep_span[5:3];
      prep_lsh  = 6'd40 - {3'b000, cur_ff[2:0]} - req_ff.bit_count;
      prep_wide = {8'd0, req_ff.write_value & low_mask(req_ff.bit_count)} << prep_lsh;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            unique case (req_ff.opcode) inside
               OP_READ, OP_WRITE: state_in = (prep_k == 3'd0) ? ST_FINISH : ST_ACCESS;
               OP_SET:            state_in = ST_FINISH;
               default:           state_in = (prep_size == 13'd0) ? ST_FINISH : ST_CLEAR;
            endcase
         end
         ST_ACCESS: begin
            if (pend_ff && (ret_ff + 3'd1 == k_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            if (sweep_ff == sweep_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath, memory control and response
   always_comb begin
      req_in        = req_ff;
      cur_in        = cur_ff;
      sweep_in      = sweep_ff;
      sweep_last_in = sweep_last_ff;
      end_in        = end_ff;
      n_in          = n_ff;
      off_in        = off_ff;
      k_in          = k_ff;
      base_in       = base_ff;
      wide_in       = wide_ff;
      acc_in        = acc_ff;
      iss_in        = iss_ff;
      ret_in        = ret_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = 8'd0;
      mem_raddr     = base_ff + AW'(iss_ff);
      fin_sh        = {k_ff, 3'b000} - {3'b000, off_ff} - n_ff;
      fin_acc       = acc_ff >> fin_sh;
      fin_set       = (req_ff.new_position > end_ff) ? end_ff : req_ff.new_position;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // zero sweep, one byte a cycle
            mem_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
         end
         ST_IDLE: begin
            req_in = req_data;
            if (req_data.bit_count > 6'(MaxBits)) begin
               req_in.bit_count = 6'(MaxBits);
            end
         end
         ST_PREP: begin
            end_in        = prep_end;
            n_in          = prep_n;
            off_in        = cur_ff[2:0];
            k_in          = prep_k;
            base_in       = AW'(cur_ff[15:3]);
            wide_in       = prep_wide;
            acc_in        = 40'd0;
            iss_in        = 3'd0;
            ret_in        = 3'd0;
            sweep_in      = '0;
            sweep_last_in = AW'(prep_size - 13'd1);
         end
         ST_ACCESS: begin
            // issue the next byte read
            if (iss_ff < k_ff) begin
               pend_in = 1'b1;
               iss_in  = iss_ff + 3'd1;
            end
            // consume the byte read last cycle
            if (pend_ff) begin
               ret_in = ret_ff + 3'd1;
               acc_in = {acc_ff[31:0], mem_rdata};
               if (req_ff.opcode == OP_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = base_ff + AW'(ret_ff);
                  mem_wdata = mem_rdata | wide_ff[39:32];
                  wide_in   = {wide_ff[31:0], 8'd0};
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in       = 1'b1;
            rsp_in.read_value  = 32'd0;
            rsp_in.read_count  = 6'd0;
            unique case (req_ff.opcode)
               OP_READ: begin
                  rsp_in.read_value = fin_acc[31:0] & low_mask(n_ff);
                  rsp_in.read_count = n_ff;
                  cur_in            = cur_ff + {10'd0, n_ff};
               end
               OP_WRITE: cur_in = cur_ff + {10'd0, n_ff};
               OP_SET:   cur_in = fin_set;
               default:  cur_in = 16'd0;
            endcase
            rsp_in.cursor_now = cur_in;
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_ff       <= 16'd0;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      sweep_last_ff <= sweep_last_in;
      end_ff        <= end_in;
      n_ff          <= n_in;
      off_ff        <= off_in;
      k_ff          <= k_in;
      base_ff       <= base_in;
      wide_ff       <= wide_in;
      acc_ff        <= acc_in;
      iss_ff        <= iss_in;
      ret_ff        <= ret_in;
      rsp_ff        <= rsp_in;
   end

   // buffer size register
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= ResetBufferBytes;
      end else if (csr_valid && csr_ready) begin
         buf_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb
   import mfbb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StoreBytes = 4096;
   localparam int unsigned BitsPerByte = 8;
   localparam int unsigned BitInByte = 7;
   localparam int unsigned ShowLimit = 10;
   localparam int unsigned SettleCycles = 20;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_SIZE,
      STEP_QUIET
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      mfbb_req_type  word;
      logic [12:0]   size;
   } plan_step_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   mfbb_req_type req_data = '0;
   logic         rsp_valid;
   mfbb_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [12:0]  csr_data = '0;

   // stimulus plan and expected response words
   plan_step_type plan_q[$];
   mfbb_rsp_type  cursor_words_due[$];
   int unsigned   words_planned = 0;
   int unsigned   words_sent = 0;
   int unsigned   mismatch_count = 0;

   // shadow copy of the buffer state
   logic [7:0]   shadow_store [StoreBytes];
   int unsigned  shadow_cursor = 0;
   logic [12:0]  shadow_size = ResetBufferBytes;

   msb_first_bit_buffer #(
      .STORE_BYTES(StoreBytes)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one request word to the shadow state, return the response it gives
   function automatic mfbb_rsp_type buffer_step(input mfbb_req_type r);
      mfbb_rsp_type w;
      int unsigned  cnt;
      int unsigned  used;
      int unsigned  bits_end;
      int unsigned  i;
      w = '0;
      cnt = (r.bit_count > MaxBits) ? MaxBits : r.bit_count;
      used = (shadow_size > StoreBytes) ? StoreBytes : shadow_size;
      bits_end = used * BitsPerByte;
      case (r.opcode)
         OP_READ: begin
            for (i = 0; i < cnt && shadow_cursor < bits_end; i++) begin
               w.read_value = {w.read_value[30:0],
                  shadow_store[shadow_cursor / BitsPerByte]
                              [BitInByte - (shadow_cursor % BitsPerByte)]};
               w.read_count = w.read_count + 6'd1;
               shadow_cursor++;
            end
         end
         OP_WRITE: begin
            for (i = cnt; i > 0 && shadow_cursor < bits_end; i--) begin
               if (r.write_value[i-1]) begin
                  shadow_store[shadow_cursor / BitsPerByte]
                              [BitInByte - (shadow_cursor % BitsPerByte)] = 1'b1;
               end
               shadow_cursor++;
            end
         end
         OP_SET: begin
            shadow_cursor = (r.new_position > bits_end) ? bits_end : r.new_position;
         end
         default: begin
            for (i = 0; i < used; i++) begin
               shadow_store[i] = '0;
            end
            shadow_cursor = 0;
         end
      endcase
      w.cursor_now = shadow_cursor[15:0];
      return w;
   endfunction

   // plan building
   task automatic add_word(input mfbb_op_type op, input logic [5:0] cnt,
                           input logic [31:0] val, input logic [15:0] pos);
      plan_step_type s;
      s.kind = STEP_WORD;
      s.word.opcode = op;
      s.word.bit_count = cnt;
      s.word.write_value = val;
      s.word.new_position = pos;
      s.size = '0;
      plan_q.push_back(s);
      words_planned++;
   endtask

   task automatic add_size(input logic [12:0] bytes);
      plan_step_type s;
      s.kind = STEP_SIZE;
      s.word = '0;
      s.size = bytes;
      plan_q.push_back(s);
   endtask

   task automatic add_quiet();
      plan_step_type s;
      s.kind = STEP_QUIET;
      s.word = '0;
      s.size = '0;
      plan_q.push_back(s);
   endtask

   // write a few fields at a spot, then seek back and read them out
   task automatic add_roundtrip(input int unsigned bits_end);
      int unsigned spot;
      int unsigned n;
      int unsigned total;
      int unsigned c;
      int unsigned i;
      spot = (bits_end == 0) ? 0 : $urandom_range(0, bits_end - 1);
      n = $urandom_range(1, 4);
      total = 0;
      add_word(OP_SET, 6'($urandom_range(0, 63)), $urandom, 16'(spot));
      for (i = 0; i < n; i++) begin
         c = $urandom_range(0, 32);
         total += c;
         add_word(OP_WRITE, 6'(c), $urandom, 16'($urandom_range(0, 65535)));
      end
      add_word(OP_SET, 6'($urandom_range(0, 63)), $urandom, 16'(spot));
      while (total > 0) begin
         c = $urandom_range(1, 32);
         add_word(OP_READ, 6'(c), $urandom, 16'($urandom_range(0, 65535)));
         total -= (c > total) ? total : c;
      end
   endtask

   // driver: request words and size writes
   always @(posedge clock) begin
      logic        next_start;
      logic        next_csr;
      logic        quiet;
      int unsigned idle_pct;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         shadow_cursor = 0;
         shadow_size = ResetBufferBytes;
         foreach (shadow_store[i]) shadow_store[i] = '0;
      end else begin
         next_start = start;
         next_csr = csr_valid;
         quiet = !start && !busy && !rsp_valid && !csr_valid && cursor_words_due.size() == 0;
         if (start && !busy) begin
            cursor_words_due.push_back(buffer_step(req_data));
            words_sent++;
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            shadow_size = csr_data;
            next_csr = 1'b0;
         end
         if (words_sent * 3 < words_planned) begin
            idle_pct = 29;
         end else if (words_sent * 3 < words_planned * 2) begin
            idle_pct = 46;
         end else begin
            idle_pct = 0;
         end
         if (!next_start && !next_csr && plan_q.size() != 0) begin
            case (plan_q[0].kind)
               STEP_WORD: begin
                  if ($urandom_range(0, 99) >= idle_pct) begin
                     req_data <= plan_q[0].word;
                     next_start = 1'b1;
                     void'(plan_q.pop_front());
                  end
               end
               STEP_SIZE: begin
                  if (quiet) begin
                     csr_data <= plan_q[0].size;
                     next_csr = 1'b1;
                     void'(plan_q.pop_front());
                  end
               end
               default: begin
                  if (quiet) void'(plan_q.pop_front());
               end
            endcase
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   task automatic note_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= ShowLimit) begin
         $display("%0t: %s mismatch, expected %h got %h", $realtime, field, want, got);
      end
   endtask

   // monitor: check each response word against the oldest expectation
   always @(posedge clock) begin
      mfbb_rsp_type want;
      if (!reset && rsp_valid) begin
         if (cursor_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ShowLimit) begin
               $display("%0t: unexpected response word %h", $realtime, rsp_data);
            end
         end else begin
            want = cursor_words_due.pop_front();
            if (rsp_data.read_value !== want.read_value)
               note_field("read_value", want.read_value, rsp_data.read_value);
            if (rsp_data.read_count !== want.read_count)
               note_field("read_count", 32'(want.read_count), 32'(rsp_data.read_count));
            if (rsp_data.cursor_now !== want.cursor_now)
               note_field("cursor_now", 32'(want.cursor_now), 32'(rsp_data.cursor_now));
         end
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned  phase;
      int unsigned  target;
      int unsigned  bytes;
      int unsigned  used;
      int unsigned  bits_end;
      int unsigned  clear_budget;
      int unsigned  c;
      mfbb_op_type  op;

      // directed: extremes, saturation, buffer end, empty and oversized buffer
      add_word(OP_READ, 6'd32, 32'h0000_0000, 16'h0000);
      add_word(OP_WRITE, 6'd32, 32'hFFFF_FFFF, 16'hFFFF);
      add_word(OP_WRITE, 6'd0, 32'h0000_0000, 16'h0000);
      add_word(OP_WRITE, 6'd63, 32'hA5A5_A5A5, 16'h1234);
      add_word(OP_WRITE, 6'd1, 32'h0000_0001, 16'h0000);
      add_word(OP_SET, 6'd0, 32'h0, 16'h0000);
      add_word(OP_READ, 6'd32, 32'h0, 16'h0);
      add_word(OP_READ, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
      add_word(OP_READ, 6'd0, 32'h0, 16'h0);
      add_word(OP_READ, 6'd1, 32'h0, 16'h0);
      add_word(OP_SET, 6'd0, 32'h0, 16'hFFFF);
      add_word(OP_READ, 6'd32, 32'h0, 16'h0);
      add_word(OP_WRITE, 6'd32, 32'hFFFF_FFFF, 16'h0);
      add_word(OP_SET, 6'd0, 32'h0, 16'd32760);
      add_word(OP_WRITE, 6'd32, 32'h1234_56FF, 16'h0);
      add_word(OP_SET, 6'd0, 32'h0, 16'd32760);
      add_word(OP_READ, 6'd32, 32'h0, 16'h0);
      add_quiet();
      add_word(OP_CLEAR, 6'd0, 32'h0, 16'h0);
      // empty buffer: nothing read or written, cursor forced to zero
      add_size(13'd0);
      add_word(OP_SET, 6'd0, 32'h0, 16'd100);
      add_word(OP_WRITE, 6'd32, 32'hFFFF_FFFF, 16'h0);
      add_word(OP_CLEAR, 6'd0, 32'h0, 16'h0);
      // size above the store counts as the whole store
      add_size(13'h1FFF);
      add_word(OP_SET, 6'd0, 32'h0, 16'hFFFF);
      // one byte: a write is cut off at the end
      add_size(13'd1);
      add_word(OP_SET, 6'd0, 32'h0, 16'd3);
      add_word(OP_WRITE, 6'd32, 32'hFFFF_FFFF, 16'h0);
      add_word(OP_SET, 6'd0, 32'h0, 16'd0);
      add_word(OP_READ, 6'd32, 32'h0, 16'h0);
      // cursor left beyond the end after the size shrinks
      add_size(13'd4096);
      add_word(OP_SET, 6'd0, 32'h0, 16'd20000);
      add_size(13'd2);
      add_word(OP_READ, 6'd8, 32'h0, 16'h0);
      add_word(OP_WRITE, 6'd8, 32'hFF, 16'h0);

      // random phases, mostly small buffers
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: bytes = 1;
            1: bytes = $urandom_range(2, 16);
            2: bytes = 4096;
            3: bytes = $urandom_range(17, 64);
            4: bytes = 0;
            5: bytes = $urandom_range(1, 64);
            6: bytes = $urandom_range(4097, 8191);
            7: bytes = $urandom_range(2, 8);
            8: bytes = $urandom_range(65, 512);
            default: bytes = $urandom_range(1, 32);
         endcase
         add_size(13'(bytes));
         used = (bytes > StoreBytes) ? StoreBytes : bytes;
         bits_end = used * BitsPerByte;
         clear_budget = (used > 64) ? 2 : 1000;
         target = words_planned + ((bytes == 0) ? 30 : 95);
         while (words_planned < target) begin
            if ($urandom_range(0, 40) == 0) add_quiet();
            if (bits_end != 0 && $urandom_range(0, 99) < 60) begin
               add_roundtrip(bits_end);
            end else begin
               op = mfbb_op_type'($urandom_range(0, 3));
               if (op == OP_CLEAR) begin
                  if (clear_budget == 0 || $urandom_range(0, 2) != 0) op = OP_SET;
                  else clear_budget--;
               end
               c = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
               add_word(op, 6'(c), $urandom,
                        ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, bits_end + 16)));
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0 || start || csr_valid || cursor_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[msb_first_bit_buffer] OK");
      end else begin
         $display("[msb_first_bit_buffer] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("[msb_first_bit_buffer] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
